[hdl/j3d_container_validator_assert.svh]
// assertion macros for the checker file
`ifndef J3D_CONTAINER_VALIDATOR_ASSERT_SVH
`define J3D_CONTAINER_VALIDATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define J3DCV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("j3dcv assertion failed");

// next-cycle implication, disabled while reset is low
`define J3DCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("j3dcv assertion failed");

`endif

[hdl/j3dcv_pkg.sv]
// ----------------------------------------------------------------------------
// j3dcv_pkg
// Types, constants and helpers shared by the container validator modules.
// ----------------------------------------------------------------------------
package j3dcv_pkg;

    // container layout
    localparam logic [31:0] HDR_SIZE     = 32'h0000_0020;
    localparam logic [31:0] SEC_HDR_SIZE = 32'h0000_0008;
    localparam logic [63:0] MAGIC_BMD    = 64'h4A33_4432_626D_6433;
    localparam logic [63:0] MAGIC_BDL    = 64'h4A33_4432_6264_6C34;

    // header byte positions
    localparam logic [31:0] POS_MAGIC_END = 32'd7;
    localparam logic [31:0] POS_SIZE_END  = 32'd11;
    localparam logic [31:0] POS_HDR_LAST  = 32'd15;

    // result queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    // record kinds
    localparam logic KIND_SECTION = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // model types
    localparam logic TYPE_BMD = 1'b0;
    localparam logic TYPE_BDL = 1'b1;

    // file status codes
    typedef enum logic [3:0] {
        ST_OK               = 4'd0,
        ST_SHORT_FILE       = 4'd1,
        ST_BAD_MAGIC        = 4'd2,
        ST_DECL_LT_HEADER   = 4'd3,
        ST_DECL_GT_FILE     = 4'd4,
        ST_COUNT_TOO_BIG    = 4'd5,
        ST_SEC_HDR_PAST_END = 4'd6,
        ST_SEC_LT_HEADER    = 4'd7,
        ST_SEC_PAST_END     = 4'd8
    } t_status;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_WALK   = 3'b100
    } t_phase;

    // input item
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [31:0] file_length;
    } t_in;

    // result item
    typedef struct packed {
        logic        record_kind;
        logic [3:0]  status_code;
        logic        model_type;
        logic [28:0] section_index;
        logic [31:0] section_tag;
        logic [31:0] section_size;
        logic [31:0] section_offset;
        logic        last_result;
    } t_out;

    // records produced for one byte, slot 1 only used together with slot 0
    typedef struct packed {
        logic push0;
        logic push1;
        t_out rec0;
        t_out rec1;
    } t_push;

    // build one result record
    function automatic t_out make_rec(input logic        kind,
                                      input t_status     code,
                                      input logic        mtype,
                                      input logic [28:0] idx,
                                      input logic [31:0] tag,
                                      input logic [31:0] size,
                                      input logic [31:0] off);
        t_out rec;
        rec.record_kind    = kind;
        rec.status_code    = code;
        rec.model_type     = mtype;
        rec.section_index  = idx;
        rec.section_tag    = tag;
        rec.section_size   = size;
        rec.section_offset = off;
        rec.last_result    = kind;
        return rec;
    endfunction

endpackage

[hdl/j3dcv_out_fifo.sv]
// ----------------------------------------------------------------------------
// j3dcv_out_fifo
// Result queue: takes up to two records per cycle, gives one per ready cycle.
// ----------------------------------------------------------------------------
module j3dcv_out_fifo #(
    parameter int unsigned DEPTH = j3dcv_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  j3dcv_pkg::t_push i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output j3dcv_pkg::t_out  o_data
);
    import j3dcv_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_out          r_mem [DEPTH];
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] w_tail1, w_tail2;
    logic          w_pop;

    // pointer steps with wrap
    assign w_tail1 = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + PW'(1);
    assign w_tail2 = (w_tail1 == PW'(DEPTH - 1)) ? '0 : w_tail1 + PW'(1);

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    // pointer and fill updates
    always_comb begin
        n_head = r_head;
        if (w_pop) begin
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
        end
        n_tail = r_tail;
        if (i_push.push0 && i_push.push1) begin
            n_tail = w_tail2;
        end else if (i_push.push0) begin
            n_tail = w_tail1;
        end
        n_count = r_count + CW'(i_push.push0) + CW'(i_push.push1) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // record storage
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_tail] <= i_push.rec0;
        end
        if (i_push.push1) begin
            r_mem[w_tail1] <= i_push.rec1;
        end
    end

endmodule

[hdl/j3dcv_core.sv]
// ----------------------------------------------------------------------------
// j3dcv_core
// Input byte register and parser state; checks the header, walks sections.
// ----------------------------------------------------------------------------
module j3dcv_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  j3dcv_pkg::t_in   i_data,
    input  logic             i_room,
    output j3dcv_pkg::t_push o_push
);
    import j3dcv_pkg::*;

    // input stage
    logic        r_in_vld;
    t_in         r_in;
    logic        w_fire;

    // parser state
    t_phase      r_phase,  n_phase;
    logic [31:0] r_pos,    n_pos;
    logic [31:0] r_total,  n_total;
    logic [63:0] r_magic,  n_magic;
    logic [31:0] r_decl,   n_decl;
    logic [31:0] r_sexp,   n_sexp;
    logic [28:0] r_seen,   n_seen;
    logic [31:0] r_start,  n_start;
    logic [63:0] r_hshift, n_hshift;
    logic        r_type,   n_type;

    // working values
    logic        w_done;
    logic        w_chk;
    logic        w_chk_slot1;
    logic [31:0] w_p;
    logic [31:0] w_diff;
    logic [31:0] w_tag;
    logic [31:0] w_size;
    logic [32:0] w_end;
    t_out        w_rec_ns;
    logic        w_ns_emit;

    assign w_fire  = r_in_vld && i_room;
    assign o_ready = !r_in_vld || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    // byte processing
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_total     = r_total;
        n_magic     = r_magic;
        n_decl      = r_decl;
        n_sexp      = r_sexp;
        n_seen      = r_seen;
        n_start     = r_start;
        n_hshift    = r_hshift;
        n_type      = r_type;
        o_push      = '0;
        w_done      = 1'b0;
        w_chk       = 1'b0;
        w_chk_slot1 = 1'b0;
        w_p         = r_pos;
        w_diff      = '0;
        w_tag       = '0;
        w_size      = '0;
        w_end       = '0;
        w_rec_ns    = '0;
        w_ns_emit   = 1'b0;

        // new file restarts everything
        if (r_in.first_byte) begin
            n_pos    = '0;
            n_magic  = '0;
            n_decl   = '0;
            n_sexp   = '0;
            n_seen   = '0;
            n_start  = '0;
            n_hshift = '0;
            n_type   = TYPE_BMD;
            n_total  = r_in.file_length;
            if (r_in.file_length < HDR_SIZE) begin
                o_push.push0 = 1'b1;
                o_push.rec0  = make_rec(KIND_STATUS, ST_SHORT_FILE, TYPE_BMD,
                                        '0, '0, '0, '0);
                n_phase = PH_IDLE;
                w_done  = 1'b1;
            end else begin
                n_phase = PH_HEADER;
            end
        end

        if (!w_done && n_phase != PH_IDLE) begin
            w_p   = n_pos;
            n_pos = w_p + 32'd1;
            case (n_phase)
                PH_HEADER: begin
                    // header field capture
                    if (w_p <= POS_MAGIC_END) begin
                        n_magic = {n_magic[55:0], r_in.data_byte};
                        if (w_p == POS_MAGIC_END) begin
                            n_type = (n_magic == MAGIC_BDL) ? TYPE_BDL : TYPE_BMD;
                        end
                    end else if (w_p <= POS_SIZE_END) begin
                        n_decl = {n_decl[23:0], r_in.data_byte};
                    end else if (w_p <= POS_HDR_LAST) begin
                        n_sexp = {n_sexp[23:0], r_in.data_byte};
                    end
                    // header verdict
                    if (w_p == POS_HDR_LAST) begin
                        o_push.push0 = 1'b1;
                        n_phase      = PH_IDLE;
                        if (n_magic != MAGIC_BMD && n_magic != MAGIC_BDL) begin
                            n_type      = TYPE_BMD;
                            o_push.rec0 = make_rec(KIND_STATUS, ST_BAD_MAGIC, TYPE_BMD,
                                                   '0, '0, '0, '0);
                        end else if (n_decl < HDR_SIZE) begin
                            o_push.rec0 = make_rec(KIND_STATUS, ST_DECL_LT_HEADER, n_type,
                                                   '0, '0, '0, '0);
                        end else if (n_decl > n_total) begin
                            o_push.rec0 = make_rec(KIND_STATUS, ST_DECL_GT_FILE, n_type,
                                                   '0, '0, '0, '0);
                        end else if (n_sexp > ((n_decl - HDR_SIZE) / SEC_HDR_SIZE)) begin
                            o_push.rec0 = make_rec(KIND_STATUS, ST_COUNT_TOO_BIG, n_type,
                                                   '0, '0, '0, '0);
                        end else begin
                            o_push.push0 = 1'b0;
                            n_start      = HDR_SIZE;
                            n_seen       = '0;
                            w_chk        = 1'b1;
                        end
                    end
                end
                PH_WALK: begin
                    // section header bytes, body bytes skipped
                    if (w_p >= n_start) begin
                        w_diff   = w_p - n_start;
                        n_hshift = {n_hshift[55:0], r_in.data_byte};
                        if (w_diff == SEC_HDR_SIZE - 32'd1) begin
                            w_tag    = n_hshift[63:32];
                            w_size   = n_hshift[31:0];
                            w_end    = {1'b0, n_start} + {1'b0, w_size};
                            n_hshift = '0;
                            o_push.push0 = 1'b1;
                            if (w_size < SEC_HDR_SIZE) begin
                                o_push.rec0 = make_rec(KIND_STATUS, ST_SEC_LT_HEADER, n_type,
                                                       n_seen, w_tag, w_size, n_start);
                                n_phase     = PH_IDLE;
                            end else if (w_end > {1'b0, n_decl}) begin
                                o_push.rec0 = make_rec(KIND_STATUS, ST_SEC_PAST_END, n_type,
                                                       n_seen, w_tag, w_size, n_start);
                                n_phase     = PH_IDLE;
                            end else begin
                                o_push.rec0 = make_rec(KIND_SECTION, ST_OK, n_type,
                                                       n_seen, w_tag, w_size, n_start);
                                n_seen      = n_seen + 29'd1;
                                n_start     = w_end[31:0];
                                w_chk       = 1'b1;
                                w_chk_slot1 = 1'b1;
                            end
                        end else if (w_diff >= SEC_HDR_SIZE) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // decide what follows once the next header position is known
        if (w_chk) begin
            if ({3'b000, n_seen} >= n_sexp) begin
                w_rec_ns  = make_rec(KIND_STATUS, ST_OK, n_type, '0, '0, '0, '0);
                w_ns_emit = 1'b1;
                n_phase   = PH_IDLE;
            end else if (({1'b0, n_start} + {1'b0, SEC_HDR_SIZE}) > {1'b0, n_decl}) begin
                w_rec_ns  = make_rec(KIND_STATUS, ST_SEC_HDR_PAST_END, n_type,
                                     n_seen, '0, '0, n_start);
                w_ns_emit = 1'b1;
                n_phase   = PH_IDLE;
            end else begin
                n_phase = PH_WALK;
            end
            if (w_ns_emit) begin
                if (w_chk_slot1) begin
                    o_push.push1 = 1'b1;
                    o_push.rec1  = w_rec_ns;
                end else begin
                    o_push.push0 = 1'b1;
                    o_push.rec0  = w_rec_ns;
                end
            end
        end

        // only a transfer in the input stage moves anything
        if (!w_fire) begin
            o_push.push0 = 1'b0;
            o_push.push1 = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pos    <= '0;
            r_total  <= '0;
            r_magic  <= '0;
            r_decl   <= '0;
            r_sexp   <= '0;
            r_seen   <= '0;
            r_start  <= '0;
            r_hshift <= '0;
            r_type   <= TYPE_BMD;
        end else if (w_fire) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_total  <= n_total;
            r_magic  <= n_magic;
            r_decl   <= n_decl;
            r_sexp   <= n_sexp;
            r_seen   <= n_seen;
            r_start  <= n_start;
            r_hshift <= n_hshift;
            r_type   <= n_type;
        end
    end

endmodule

[hdl/j3d_container_validator.sv]
// path: a byte transfer lands in the input register, is parsed from there, and its
// records are written into the queue, which offers them to the receiver in order
// throughput: one byte per cycle; input stalls while fewer than two queue entries are
// free; a section's closing byte may yield two records, drained one per ready cycle
// reset: synchronous active low, parser idle, input stage and queue empty
// ----------------------------------------------------------------------------
// j3d_container_validator
// Byte-serial checker for J3D model containers, one record per accepted section and
// a final status per file whose header or section walk comes to a verdict.
// ----------------------------------------------------------------------------
module j3d_container_validator #(
    parameter int unsigned QUEUE_DEPTH = j3dcv_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  j3dcv_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output j3dcv_pkg::t_out o_data
);
    import j3dcv_pkg::*;

    t_push w_push;
    logic  w_room;

    // parser
    j3dcv_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    // result queue
    j3dcv_out_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

[hdl/j3dcv_checker.sv]
// ----------------------------------------------------------------------------
// j3dcv_checker
// Port-level assertions for the container validator, bound to the top level.
// ----------------------------------------------------------------------------
`include "j3d_container_validator_assert.svh"

module j3dcv_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input j3dcv_pkg::t_in  i_data,
    input logic            o_valid,
    input logic            i_ready,
    input j3dcv_pkg::t_out o_data
);
    import j3dcv_pkg::*;

    // a stalled result stays offered
    `J3DCV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // a stalled result keeps its payload
    `J3DCV_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_data))

    // a file status always closes the file, a section record never does
    `J3DCV_ASSERT_NOW(a_last_on_status, i_clk, i_rst_n, o_valid,
        o_data.last_result == o_data.record_kind)

    // section records carry the ok code
    `J3DCV_ASSERT_NOW(a_section_ok, i_clk, i_rst_n,
        o_valid && (o_data.record_kind == KIND_SECTION),
        o_data.status_code == ST_OK)

    // status codes stay within the defined set
    `J3DCV_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_valid,
        o_data.status_code <= ST_SEC_PAST_END)

endmodule

bind j3d_container_validator j3dcv_checker u_checker (.*);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Feeds whole and damaged J3D containers into j3d_container_validator one byte
// per transfer, predicts every section record and file status in a scoreboard
// class, and compares each result field by field under random sender idling
// and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import j3dcv_pkg::*;

    localparam int unsigned TOTAL_BYTES    = 1900;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 6;
    localparam int unsigned FILES_PER_MODE = 6;

    // kinds of container the stimulus builds
    typedef enum int {
        FILE_GOOD,
        FILE_BAD_MAGIC,
        FILE_SMALL_DECL,
        FILE_BIG_DECL,
        FILE_MANY_SECTIONS,
        FILE_SEC_HDR_CUT,
        FILE_SEC_TOO_SMALL,
        FILE_SEC_TOO_BIG,
        FILE_ABANDONED,
        FILE_SHORT,
        FILE_NOISE,
        FILE_KIND_COUNT
    } t_file_kind;

    // ------------------------------------------------------------------------
    // scoreboard: tracks the parser state and holds the records still owed
    // ------------------------------------------------------------------------
    class container_scoreboard;
        t_phase      phase;
        logic [31:0] byte_pos;
        logic [31:0] total_len;
        logic [63:0] magic_sr;
        logic [31:0] decl_size;
        logic [31:0] sec_expected;
        logic [31:0] sec_seen;
        logic [31:0] sec_start;
        logic [63:0] hdr_sr;
        logic        type_bit;
        t_out        expected_records[$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase        = PH_IDLE;
            byte_pos     = '0;
            total_len    = '0;
            magic_sr     = '0;
            decl_size    = '0;
            sec_expected = '0;
            sec_seen     = '0;
            sec_start    = '0;
            hdr_sr       = '0;
            type_bit     = 1'b0;
        endfunction

        function void push_rec(logic kind, t_status code, logic [31:0] idx,
                               logic [31:0] tag, logic [31:0] size, logic [31:0] off);
            t_out rec;
            rec.record_kind    = kind;
            rec.status_code    = code;
            rec.model_type     = type_bit;
            rec.section_index  = idx[28:0];
            rec.section_tag    = tag;
            rec.section_size   = size;
            rec.section_offset = off;
            rec.last_result    = kind;
            expected_records = {expected_records, rec};
            if (kind == KIND_STATUS) begin
                phase = PH_IDLE;
            end
        endfunction

        // decide what follows once sec_start points at the next header
        function void advance_section();
            if (sec_seen >= sec_expected) begin
                push_rec(KIND_STATUS, ST_OK, 0, 0, 0, 0);
            end else if (33'(sec_start) + 33'(SEC_HDR_SIZE) > 33'(decl_size)) begin
                push_rec(KIND_STATUS, ST_SEC_HDR_PAST_END, sec_seen, 0, 0, sec_start);
            end else begin
                phase = PH_WALK;
            end
        endfunction

        // one accepted byte transfer
        function void note_byte(t_in item);
            logic [31:0] p;
            logic [31:0] tag;
            logic [31:0] size;
            logic [32:0] sec_end;
            if (item.first_byte) begin
                clear();
                total_len = item.file_length;
                if (total_len < HDR_SIZE) begin
                    push_rec(KIND_STATUS, ST_SHORT_FILE, 0, 0, 0, 0);
                    return;
                end
                phase = PH_HEADER;
            end
            if (phase == PH_IDLE) begin
                return;
            end
            p = byte_pos;
            byte_pos = p + 1;

            // fixed header fields
            if (phase == PH_HEADER) begin
                if (p <= POS_MAGIC_END) begin
                    magic_sr = {magic_sr[55:0], item.data_byte};
                    if (p == POS_MAGIC_END) begin
                        type_bit = (magic_sr == MAGIC_BDL);
                    end
                end else if (p <= POS_SIZE_END) begin
                    decl_size = {decl_size[23:0], item.data_byte};
                end else if (p <= POS_HDR_LAST) begin
                    sec_expected = {sec_expected[23:0], item.data_byte};
                end
                if (p == POS_HDR_LAST) begin
                    if (magic_sr != MAGIC_BMD && magic_sr != MAGIC_BDL) begin
                        type_bit = 1'b0;
                        push_rec(KIND_STATUS, ST_BAD_MAGIC, 0, 0, 0, 0);
                    end else if (decl_size < HDR_SIZE) begin
                        push_rec(KIND_STATUS, ST_DECL_LT_HEADER, 0, 0, 0, 0);
                    end else if (decl_size > total_len) begin
                        push_rec(KIND_STATUS, ST_DECL_GT_FILE, 0, 0, 0, 0);
                    end else if (sec_expected > (decl_size - HDR_SIZE) / SEC_HDR_SIZE) begin
                        push_rec(KIND_STATUS, ST_COUNT_TOO_BIG, 0, 0, 0, 0);
                    end else begin
                        sec_start = HDR_SIZE;
                        sec_seen  = '0;
                        advance_section();
                    end
                end
                return;
            end

            // section walk, bodies skipped
            if (p < sec_start) begin
                return;
            end
            hdr_sr = {hdr_sr[55:0], item.data_byte};
            if (p - sec_start == SEC_HDR_SIZE - 1) begin
                tag     = hdr_sr[63:32];
                size    = hdr_sr[31:0];
                sec_end = 33'(sec_start) + 33'(size);
                hdr_sr  = '0;
                if (size < SEC_HDR_SIZE) begin
                    push_rec(KIND_STATUS, ST_SEC_LT_HEADER, sec_seen, tag, size, sec_start);
                end else if (sec_end > 33'(decl_size)) begin
                    push_rec(KIND_STATUS, ST_SEC_PAST_END, sec_seen, tag, size, sec_start);
                end else begin
                    push_rec(KIND_SECTION, ST_OK, sec_seen, tag, size, sec_start);
                    sec_seen++;
                    sec_start = sec_end[31:0];
                    advance_section();
                end
            end else if (p - sec_start >= SEC_HDR_SIZE) begin
                phase = PH_IDLE;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // one accepted result transfer
        function void check_record(t_out got);
            t_out want;
            if (expected_records.size() == 0) begin
                $error("unexpected record: kind %0d status %0d index %0d",
                       got.record_kind, got.status_code, got.section_index);
                errors++;
                return;
            end
            want = expected_records.pop_front();
            compare_field("record_kind", want.record_kind, got.record_kind);
            compare_field("status_code", want.status_code, got.status_code);
            compare_field("model_type", want.model_type, got.model_type);
            compare_field("section_index", want.section_index, got.section_index);
            compare_field("section_tag", want.section_tag, got.section_tag);
            compare_field("section_size", want.section_size, got.section_size);
            compare_field("section_offset", want.section_offset, got.section_offset);
            compare_field("last_result", want.last_result, got.last_result);
        endfunction
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_in   i_data;
    logic  o_valid;
    logic  i_ready;
    t_out  o_data;

    container_scoreboard scoreboard;
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;
    int unsigned         bytes_sent;
    int unsigned         quiet_cycles;
    logic [7:0]          file_bytes[$];
    logic [31:0]         file_len_field;
    int unsigned         send_count;

    j3d_container_validator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #6 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                scoreboard.note_byte(i_data);
            end
            if (o_valid && i_ready) begin
                scoreboard.check_record(o_data);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic void push32(logic [31:0] value);
        for (int i = 3; i >= 0; i--) begin
            file_bytes = {file_bytes, value[8*i +: 8]};
        end
    endfunction

    function automatic void put32(int unsigned pos, logic [31:0] value);
        for (int i = 0; i < 4; i++) begin
            file_bytes[pos + i] = value[8*(3-i) +: 8];
        end
    endfunction

    // build one container, sound or damaged as the kind says
    function automatic void build_container(t_file_kind kind, bit extreme);
        int unsigned nsec;
        int unsigned j;
        int unsigned pad;
        logic [31:0] size;
        logic [31:0] decl;
        logic [31:0] count;
        logic [31:0] flen;
        logic [31:0] room;
        logic [31:0] offs[$];
        logic [63:0] magic;
        file_bytes.delete();
        nsec = $urandom_range(0, 3);
        if (kind == FILE_GOOD && extreme) begin
            nsec = 0;
        end
        if (kind inside {FILE_SEC_HDR_CUT, FILE_SEC_TOO_SMALL, FILE_SEC_TOO_BIG}) begin
            nsec = $urandom_range(1, 3);
        end
        magic = $urandom_range(0, 1) ? MAGIC_BDL : MAGIC_BMD;
        push32(magic[63:32]);
        push32(magic[31:0]);
        push32('0);
        push32('0);
        for (int i = 0; i < 16; i++) begin
            file_bytes = {file_bytes, 8'($urandom)};
        end

        // sections, larger ones when a missing header must fit the count
        decl = HDR_SIZE;
        for (int i = 0; i < nsec; i++) begin
            size = SEC_HDR_SIZE + $urandom_range(0, 8);
            if (kind == FILE_SEC_HDR_CUT) begin
                size = size + SEC_HDR_SIZE;
            end
            offs = {offs, decl};
            push32($urandom);
            push32(size);
            for (int b = 0; b < size - SEC_HDR_SIZE; b++) begin
                file_bytes = {file_bytes, 8'($urandom)};
            end
            decl = decl + size;
        end
        if ($urandom_range(0, 3) == 0 && !(kind == FILE_GOOD && extreme)) begin
            pad = $urandom_range(1, 7);
            for (int i = 0; i < pad; i++) begin
                file_bytes = {file_bytes, 8'($urandom)};
            end
            decl = decl + pad;
        end
        count = nsec;
        flen = $urandom_range(0, 1) ? decl : $urandom_range(decl, 32'hFFFF_FFFF);
        if (extreme) begin
            flen = 32'hFFFF_FFFF;
        end
        send_count = file_bytes.size();

        case (kind)
            FILE_BAD_MAGIC: begin
                if (extreme) begin
                    for (int i = 0; i < 8; i++) file_bytes[i] = 8'h00;
                end else begin
                    j = $urandom_range(0, 63);
                    file_bytes[j / 8] = file_bytes[j / 8] ^ (8'h01 << (j % 8));
                end
            end
            FILE_SMALL_DECL: begin
                decl = extreme ? 32'd0 : $urandom_range(0, HDR_SIZE - 1);
            end
            FILE_BIG_DECL: begin
                flen = extreme ? 32'hFFFF_FFFE : $urandom_range(HDR_SIZE, 32'hFFFF_FFFE);
                decl = extreme ? 32'hFFFF_FFFF : $urandom_range(flen + 1, 32'hFFFF_FFFF);
            end
            FILE_MANY_SECTIONS: begin
                room = (decl - HDR_SIZE) / SEC_HDR_SIZE;
                if (extreme) begin
                    count = 32'hFFFF_FFFF;
                end else begin
                    count = $urandom_range(0, 1) ? room + 1
                                                 : $urandom_range(room + 1, 32'hFFFF_FFFF);
                end
            end
            FILE_SEC_HDR_CUT: begin
                room = (decl - HDR_SIZE) / SEC_HDR_SIZE;
                count = extreme ? room : $urandom_range(nsec + 1, room);
            end
            FILE_SEC_TOO_SMALL: begin
                j = $urandom_range(0, nsec - 1);
                put32(offs[j] + 4, extreme ? 32'd0 : $urandom_range(0, SEC_HDR_SIZE - 1));
            end
            FILE_SEC_TOO_BIG: begin
                j = $urandom_range(0, nsec - 1);
                put32(offs[j] + 4, extreme ? 32'hFFFF_FFFF
                                           : $urandom_range(decl - offs[j] + 1, 32'hFFFF_FFFF));
            end
            FILE_ABANDONED: begin
                send_count = extreme ? 1 : $urandom_range(1, file_bytes.size() - 1);
            end
            FILE_SHORT: begin
                flen = extreme ? 32'd0 : $urandom_range(0, HDR_SIZE - 1);
                send_count = $urandom_range(1, file_bytes.size());
            end
            FILE_NOISE: begin
                file_bytes.delete();
                send_count = $urandom_range(1, 40);
                for (int i = 0; i < send_count; i++) begin
                    file_bytes = {file_bytes, (extreme ? 8'hFF : 8'($urandom))};
                end
                flen = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom;
            end
            default: ;
        endcase
        if (kind != FILE_NOISE) begin
            put32(8, decl);
            put32(12, count);
        end
        file_len_field = flen;
    endfunction

    // one byte transfer, with random idling ahead of it
    task automatic send_byte(input t_in item);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_stray_bytes(input int unsigned n);
        t_in item;
        for (int i = 0; i < n; i++) begin
            item.data_byte   = 8'($urandom);
            item.first_byte  = 1'b0;
            item.file_length = $urandom;
            send_byte(item);
        end
    endtask

    task automatic send_file();
        t_in item;
        for (int i = 0; i < send_count; i++) begin
            item.data_byte   = file_bytes[i];
            item.first_byte  = (i == 0);
            item.file_length = (i == 0) ? file_len_field : $urandom;
            send_byte(item);
        end
    endtask

    // hold the sender until every owed record has come out
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    initial begin
        int unsigned target;
        int unsigned file_no;
        int unsigned pick;
        t_file_kind  kind;
        scoreboard     = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        quiet_cycles   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stray bytes, a good file, each kind at its extremes, a stray byte
        send_stray_bytes(2);
        build_container(FILE_GOOD, 1'b0);
        send_file();
        for (int k = 0; k < FILE_KIND_COUNT; k++) begin
            build_container(t_file_kind'(k), 1'b1);
            send_file();
        end
        send_stray_bytes(1);
        wait_for_drain();

        // random containers up to the byte budget, idling mode changes every few files
        target  = TOTAL_BYTES;
        file_no = 0;
        while (bytes_sent < target) begin
            if (file_no % FILES_PER_MODE == 0) begin
                wait_for_drain();
                set_idling((file_no / FILES_PER_MODE) % 4);
            end
            if ($urandom_range(0, 9) == 0) begin
                send_stray_bytes($urandom_range(1, 3));
            end
            pick = $urandom_range(0, 99);
            kind = (pick < 45) ? FILE_GOOD : t_file_kind'(1 + (pick - 45) % 10);
            build_container(kind, $urandom_range(0, 7) == 0);
            send_file();
            file_no++;
        end

        // end of run
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/j3dcv_pkg.sv
hdl/j3dcv_out_fifo.sv
hdl/j3dcv_core.sv
hdl/j3d_container_validator.sv
hdl/j3dcv_checker.sv
test/testbench.sv
